// ===== hdl/tlrg_pkg.sv =====
// ---------------------------------------------------------------------------
// tlrg_pkg
// Shared types and constants for the trail line refit with residual gate.
// ---------------------------------------------------------------------------
package tlrg_pkg;

    localparam int COORD_W        = 24;
    localparam int LINE_W         = 32;
    localparam int CNT_W          = 13;
    localparam int SX_W           = 37;
    localparam int SXX_W          = 59;
    localparam int SXY_W          = 60;
    localparam int RADIUS_W       = 23;
    localparam int TRAIL_W        = 22;
    localparam int CFG_W          = 23;
    localparam int CFG_IDX_W      = 2;
    localparam int DW             = 100;   // solver datapath width
    localparam int QUEUE_DEPTH    = 4;
    localparam int MAX_POINTS_DEF = 4096;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 23'd25600;
    localparam logic [TRAIL_W-1:0]  TRAIL_RST  = 22'd1280;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIL  = 2'd1;

    typedef struct packed {
        logic                      req_type;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [LINE_W-1:0]  slope;
        logic signed [LINE_W-1:0]  intercept;
        logic                      axis;
        logic                      last;
    } in_word_t;

    typedef struct packed {
        logic signed [LINE_W-1:0] fit_slope;
        logic signed [LINE_W-1:0] fit_intercept;
        logic [CNT_W-1:0]         point_count;
        logic                     degenerate;
    } out_word_t;

    // Sums of one finished job, already mapped to the fit axis (u independent).
    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SX_W-1:0]  su;
        logic signed [SX_W-1:0]  sv;
        logic signed [SXX_W-1:0] suu;
        logic signed [SXY_W-1:0] suv;
    } job_t;

endpackage

// ===== hdl/tlrg_front.sv =====
// ---------------------------------------------------------------------------
// tlrg_front
// Gates points against seed window and prior line, keeps the running sums.
// ---------------------------------------------------------------------------
module tlrg_front #(
    parameter int MAX_POINTS = tlrg_pkg::MAX_POINTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               take,
    input  tlrg_pkg::in_word_t                 in_word,
    input  logic [tlrg_pkg::RADIUS_W-1:0]      radius,
    input  logic [tlrg_pkg::TRAIL_W-1:0]       trail_half,
    output logic                               job_push,
    output tlrg_pkg::job_t                     job,
    output logic                               last_pending
);

    localparam int CW = tlrg_pkg::CNT_W;

    logic signed [tlrg_pkg::COORD_W-1:0] seed_x_reg, seed_y_reg;
    logic signed [tlrg_pkg::LINE_W-1:0]  prior_slope_reg, prior_int_reg;
    logic                                fit_axis_reg;

    logic        st1_valid_reg, st1_start_reg, st1_last_reg, st1_win_reg, st1_axis_reg;
    logic signed [55:0] st1_prod_reg;
    logic signed [32:0] st1_vb_reg;
    logic signed [23:0] st1_x_reg, st1_y_reg;
    logic signed [47:0] st1_xx_reg, st1_yy_reg, st1_xy_reg;

    logic signed [tlrg_pkg::SX_W-1:0]  sum_x_reg, sum_y_reg, sum_x_next, sum_y_next;
    logic signed [tlrg_pkg::SXX_W-1:0] sum_xx_reg, sum_yy_reg, sum_xx_next, sum_yy_next;
    logic signed [tlrg_pkg::SXY_W-1:0] sum_xy_reg, sum_xy_next;
    logic [CW-1:0]                     count_reg, count_next;

    // stage 1 terms
    logic signed [24:0] dx, dy;
    logic [24:0]        adx, ady;
    logic signed [23:0] u, v;
    logic               in_win;
    logic signed [55:0] prod;
    logic signed [32:0] vb;

    always_comb begin
        dx     = 25'(in_word.x) - 25'(seed_x_reg);
        dy     = 25'(in_word.y) - 25'(seed_y_reg);
        adx    = dx[24] ? 25'(-dx) : 25'(dx);
        ady    = dy[24] ? 25'(-dy) : 25'(dy);
        in_win = (adx < {2'b00, radius}) && (ady < {2'b00, radius});
        u      = fit_axis_reg ? in_word.y : in_word.x;
        v      = fit_axis_reg ? in_word.x : in_word.y;
        prod   = 56'(prior_slope_reg) * 56'(u);
        vb     = 33'(v) - 33'(prior_int_reg);
    end

    // stage 2: residual check and accumulate
    logic signed [57:0] delta;
    logic [57:0]        adelta;
    logic               hit;

    always_comb begin
        delta  = (58'(st1_vb_reg) <<< 16) - 58'(st1_prod_reg);
        adelta = delta[57] ? 58'(-delta) : 58'(delta);
        hit    = st1_win_reg && (adelta < 58'({trail_half, 17'd0}))
                 && (count_reg < CW'(MAX_POINTS));
        sum_x_next  = sum_x_reg  + (hit ? 37'(st1_x_reg)  : 37'sd0);
        sum_y_next  = sum_y_reg  + (hit ? 37'(st1_y_reg)  : 37'sd0);
        sum_xx_next = sum_xx_reg + (hit ? 59'(st1_xx_reg) : 59'sd0);
        sum_yy_next = sum_yy_reg + (hit ? 59'(st1_yy_reg) : 59'sd0);
        sum_xy_next = sum_xy_reg + (hit ? 60'(st1_xy_reg) : 60'sd0);
        count_next  = count_reg + CW'(hit);
        job_push    = st1_valid_reg && !st1_start_reg && st1_last_reg;
        job.n       = count_next;
        job.su      = st1_axis_reg ? sum_y_next : sum_x_next;
        job.sv      = st1_axis_reg ? sum_x_next : sum_y_next;
        job.suu     = st1_axis_reg ? sum_yy_next : sum_xx_next;
        job.suv     = sum_xy_next;
        last_pending = job_push;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_x_reg      <= '0;
            seed_y_reg      <= '0;
            prior_slope_reg <= '0;
            prior_int_reg   <= '0;
            fit_axis_reg    <= 1'b0;
            st1_valid_reg   <= 1'b0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_xx_reg      <= '0;
            sum_yy_reg      <= '0;
            sum_xy_reg      <= '0;
            count_reg       <= '0;
        end else begin
            st1_valid_reg <= take;
            if (take) begin
                st1_start_reg <= (in_word.req_type == tlrg_pkg::REQ_START);
                st1_last_reg  <= in_word.last;
                st1_win_reg   <= in_win;
                st1_axis_reg  <= fit_axis_reg;
                st1_prod_reg  <= prod;
                st1_vb_reg    <= vb;
                st1_x_reg     <= in_word.x;
                st1_y_reg     <= in_word.y;
                st1_xx_reg    <= 48'(in_word.x) * 48'(in_word.x);
                st1_yy_reg    <= 48'(in_word.y) * 48'(in_word.y);
                st1_xy_reg    <= 48'(in_word.x) * 48'(in_word.y);
                if (in_word.req_type == tlrg_pkg::REQ_START) begin
                    seed_x_reg      <= in_word.x;
                    seed_y_reg      <= in_word.y;
                    prior_slope_reg <= in_word.slope;
                    prior_int_reg   <= in_word.intercept;
                    fit_axis_reg    <= in_word.axis;
                end
            end
            if (st1_valid_reg) begin
                if (st1_start_reg || st1_last_reg) begin
                    sum_x_reg  <= '0;
                    sum_y_reg  <= '0;
                    sum_xx_reg <= '0;
                    sum_yy_reg <= '0;
                    sum_xy_reg <= '0;
                    count_reg  <= '0;
                end else begin
                    sum_x_reg  <= sum_x_next;
                    sum_y_reg  <= sum_y_next;
                    sum_xx_reg <= sum_xx_next;
                    sum_yy_reg <= sum_yy_next;
                    sum_xy_reg <= sum_xy_next;
                    count_reg  <= count_next;
                end
            end
        end
    end

endmodule

// ===== hdl/tlrg_queue.sv =====
// ---------------------------------------------------------------------------
// tlrg_queue
// Small FIFO of finished jobs between the front and the solver.
// ---------------------------------------------------------------------------
module tlrg_queue (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      push,
    input  tlrg_pkg::job_t                            push_job,
    input  logic                                      pop,
    output logic                                      head_valid,
    output tlrg_pkg::job_t                            head_job,
    output logic [$clog2(tlrg_pkg::QUEUE_DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(tlrg_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tlrg_pkg::QUEUE_DEPTH+1);

    tlrg_pkg::job_t   mem_reg [tlrg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_job;
                wr_ptr_reg          <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

// ===== hdl/tlrg_div.sv =====
// ---------------------------------------------------------------------------
// tlrg_div
// Restoring divider, one quotient bit per cycle, rounded and saturated.
// ---------------------------------------------------------------------------
module tlrg_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [tlrg_pkg::DW-1:0]   num,
    input  logic signed [tlrg_pkg::DW-1:0]   den,
    output logic                             done,
    output logic signed [tlrg_pkg::LINE_W-1:0] quo
);

    localparam int DW = tlrg_pkg::DW;
    localparam int KW = $clog2(DW);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

    dstate_t         state_reg;
    logic            neg_reg, done_reg;
    logic [DW-1:0]   d_reg, q_reg;
    logic [DW:0]     r_reg;
    logic [KW-1:0]   cnt_reg;
    logic signed [tlrg_pkg::LINE_W-1:0] quo_reg;

    logic [DW:0]     rs, lim, qr, qs;
    logic            ge;

    always_comb begin
        rs  = {r_reg[DW-1:0], q_reg[DW-1]};
        ge  = (rs >= {1'b0, d_reg});
        lim = neg_reg ? (DW+1)'(33'h080000000) : (DW+1)'(33'h07FFFFFFF);
        qr  = {1'b0, q_reg} + (DW+1)'(({r_reg, 1'b0} >= {2'b00, d_reg}));
        qs  = (qr > lim) ? lim : qr;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        neg_reg   <= num[DW-1] ^ den[DW-1];
                        q_reg     <= num[DW-1] ? DW'(-num) : DW'(num);
                        d_reg     <= den[DW-1] ? DW'(-den) : DW'(den);
                        r_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_reg   <= ge ? (rs - {1'b0, d_reg}) : rs;
                    q_reg   <= {q_reg[DW-2:0], ge};
                    cnt_reg <= cnt_reg + KW'(1);
                    if (cnt_reg == KW'(DW-1)) begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX: begin
                    quo_reg   <= neg_reg ? -$signed(qs[31:0]) : $signed(qs[31:0]);
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/tlrg_solve.sv =====
// ---------------------------------------------------------------------------
// tlrg_solve
// Least-squares solve: six sequential products, then two divisions unless the determinant is zero.
// ---------------------------------------------------------------------------
module tlrg_solve (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  tlrg_pkg::job_t      job_in,
    output logic                job_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output tlrg_pkg::out_word_t m_data
);

    localparam int DW = tlrg_pkg::DW;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_MUL, S_ACC, S_CHECK,
        S_DIVM_GO, S_DIVM_WAIT, S_DIVB_GO, S_DIVB_WAIT, S_OUT
    } state_t;

    state_t              state_reg;
    tlrg_pkg::job_t      job_reg;
    logic [2:0]          idx_reg;
    logic [1:0]          chunk_reg;
    logic [63:0]         mag_a_reg, mag_b_reg;
    logic                neg_reg;
    logic [127:0]        acc_reg;
    logic signed [DW-1:0] det_reg, nm_reg, nb_reg;
    logic signed [tlrg_pkg::LINE_W-1:0] slope_q_reg;
    logic                m_valid_reg;
    tlrg_pkg::out_word_t m_data_reg;

    logic signed [63:0]  op_a, op_b;
    logic [79:0]         pp;
    logic signed [DW-1:0] prod, det_next, nm_next, nb_next;
    logic                div_start, div_done;
    logic signed [DW-1:0] div_num;
    logic signed [tlrg_pkg::LINE_W-1:0] div_quo;

    // operand pairs: det = n*Suu - Su*Su, m = n*Suv - Su*Sv, b = Suu*Sv - Suv*Su
    // Suu is a sum of squares and may fill all of its bits: zero-extend it
    always_comb begin
        case (idx_reg)
            3'd0:    begin
                op_a = 64'($signed({1'b0, job_reg.n}));
                op_b = 64'($unsigned(job_reg.suu));
            end
            3'd1:    begin op_a = 64'(job_reg.su);  op_b = 64'(job_reg.su); end
            3'd2:    begin op_a = 64'($signed({1'b0, job_reg.n})); op_b = 64'(job_reg.suv); end
            3'd3:    begin op_a = 64'(job_reg.su);  op_b = 64'(job_reg.sv); end
            3'd4:    begin op_a = 64'($unsigned(job_reg.suu)); op_b = 64'(job_reg.sv); end
            default: begin op_a = 64'(job_reg.suv); op_b = 64'(job_reg.su); end
        endcase
        pp       = {16'd0, mag_a_reg} * {64'd0, mag_b_reg[63:48]};
        prod     = neg_reg ? -$signed(acc_reg[DW-1:0]) : $signed(acc_reg[DW-1:0]);
        det_next = idx_reg[0] ? det_reg - prod : prod;
        nm_next  = idx_reg[0] ? nm_reg - prod : prod;
        nb_next  = idx_reg[0] ? nb_reg - prod : prod;
        div_start = (state_reg == S_DIVM_GO) || (state_reg == S_DIVB_GO);
        div_num   = (state_reg == S_DIVM_GO) ? (nm_reg <<< 16) : nb_reg;
        job_pop   = (state_reg == S_IDLE) && job_valid;
    end

    tlrg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (det_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        job_reg   <= job_in;
                        idx_reg   <= '0;
                        state_reg <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    mag_a_reg <= op_a[63] ? 64'(-op_a) : 64'(op_a);
                    mag_b_reg <= op_b[63] ? 64'(-op_b) : 64'(op_b);
                    neg_reg   <= op_a[63] ^ op_b[63];
                    acc_reg   <= '0;
                    chunk_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    acc_reg   <= (acc_reg << 16) + 128'(pp);
                    mag_b_reg <= mag_b_reg << 16;
                    chunk_reg <= chunk_reg + 2'd1;
                    if (chunk_reg == 2'd3) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    case (idx_reg[2:1])
                        2'd0:    det_reg <= det_next;
                        2'd1:    nm_reg  <= nm_next;
                        default: nb_reg  <= nb_next;
                    endcase
                    if (idx_reg == 3'd5) begin
                        state_reg <= S_CHECK;
                    end else begin
                        idx_reg   <= idx_reg + 3'd1;
                        state_reg <= S_SETUP;
                    end
                end
                S_CHECK: begin
                    if (det_reg == '0) begin
                        m_data_reg.fit_slope     <= '0;
                        m_data_reg.fit_intercept <= '0;
                        m_data_reg.point_count   <= job_reg.n;
                        m_data_reg.degenerate    <= 1'b1;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= S_OUT;
                    end else begin
                        state_reg <= S_DIVM_GO;
                    end
                end
                S_DIVM_GO: state_reg <= S_DIVM_WAIT;
                S_DIVM_WAIT: begin
                    if (div_done) begin
                        slope_q_reg <= div_quo;
                        state_reg   <= S_DIVB_GO;
                    end
                end
                S_DIVB_GO: state_reg <= S_DIVB_WAIT;
                S_DIVB_WAIT: begin
                    if (div_done) begin
                        m_data_reg.fit_slope     <= slope_q_reg;
                        m_data_reg.fit_intercept <= div_quo;
                        m_data_reg.point_count   <= job_reg.n;
                        m_data_reg.degenerate    <= 1'b0;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/trail_line_refit_residual_gate_unit.sv =====
// ---------------------------------------------------------------------------
// trail_line_refit_residual_gate_unit
// Refits a line to the points near a seed, gated by the prior line residual.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel (valid/ready) takes one word per cycle while s_ready is high:
//   a start word loads the seed, prior line and axis and clears the sums;
//   point words are gated and summed. A point word with last set closes the
//   job and queues it for the solver.
//   m_ channel (valid/ready) gives one word per closed job: slope, intercept,
//   point count and the degenerate flag.
//   cfg_we/cfg_index/cfg_data write radius (index 0) and the trail half-width
//   (index 1); write only while the block is idle.
// Timing:
//   Start and point words: 1 per cycle while s_ready is high; the sums update
//   after the stage 1 registers. A closing word yields its result after the
//   queue and the solver: six products on the shared 64x16 multiplier, a
//   check state, then two passes of the bit-serial divider.
//   A degenerate fit skips the divider.
//   Up to 4 closed jobs wait in the queue; s_ready drops when it is full.
// Reset (aresetn low, synchronous): sums, seed, prior line, queue and m_valid
//   clear; registers return to radius 25600 and trail half-width 1280.
// A stalled m_ready holds the result; the front keeps taking points until
//   the job queue fills.
// ---------------------------------------------------------------------------
module trail_line_refit_residual_gate_unit #(
    parameter int MAX_POINTS = tlrg_pkg::MAX_POINTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tlrg_pkg::in_word_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tlrg_pkg::out_word_t                m_data,
    input  logic                               cfg_we,
    input  logic [tlrg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tlrg_pkg::CFG_W-1:0]         cfg_data
);

    localparam int QCW = $clog2(tlrg_pkg::QUEUE_DEPTH+1);

    logic [tlrg_pkg::RADIUS_W-1:0] radius_reg;
    logic [tlrg_pkg::TRAIL_W-1:0]  trail_reg;

    logic           take, job_push, job_pop, head_valid, last_pending;
    tlrg_pkg::job_t push_job, head_job;
    logic [QCW-1:0] q_count;

    // reserve a queue slot for a closing word still inside the front
    assign s_ready = ({1'b0, q_count} + (QCW+1)'(last_pending))
                     < (QCW+1)'(tlrg_pkg::QUEUE_DEPTH);
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= tlrg_pkg::RADIUS_RST;
            trail_reg  <= tlrg_pkg::TRAIL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                tlrg_pkg::REG_RADIUS: radius_reg <= cfg_data[tlrg_pkg::RADIUS_W-1:0];
                tlrg_pkg::REG_TRAIL:  trail_reg  <= cfg_data[tlrg_pkg::TRAIL_W-1:0];
                default: ;
            endcase
        end
    end

    tlrg_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .in_word      (s_data),
        .radius       (radius_reg),
        .trail_half   (trail_reg),
        .job_push     (job_push),
        .job          (push_job),
        .last_pending (last_pending)
    );

    tlrg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_job   (push_job),
        .pop        (job_pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .count      (q_count)
    );

    tlrg_solve u_solve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (head_valid),
        .job_in    (head_job),
        .job_pop   (job_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hdl/tlrg_checker.sv =====
// ---------------------------------------------------------------------------
// tlrg_checker
// Port-level checks for the refit unit.
// ---------------------------------------------------------------------------
module tlrg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input tlrg_pkg::out_word_t m_data
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |->
            m_data.fit_slope == '0 && m_data.fit_intercept == '0)
        else $error("degenerate fit with nonzero line");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.point_count <= 13'd4096)
        else $error("point count over limit");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind trail_line_refit_residual_gate_unit tlrg_checker u_tlrg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
